// ----- rtl/median3x3_rgb_filter_assert.svh -----
// Assertion macros shared by the 3x3 median filter RTL.
// Each macro expects signals named clk and rst in the including scope.
`ifndef MEDIAN3X3_RGB_FILTER_ASSERT_SVH
`define MEDIAN3X3_RGB_FILTER_ASSERT_SVH
// Condition that must hold at every clock edge outside reset.
`define MED3_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Condition that must hold in the same cycle as its trigger.
`define MED3_ASSERT_IMPLIES(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);
// Condition that must hold in the cycle after its trigger.
`define MED3_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);
`endif

// ----- rtl/med3_pkg.sv -----
// Package of the 3x3 median filter: register codes, opcodes and the median network.
// Used by the channel interfaces and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package med3_pkg;

  localparam int CFG_DATA_BITS  = 11;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_DATA_BITS-1:0] FRAME_WIDTH_RESET  = 11'd1024;
  localparam logic [CFG_DATA_BITS-1:0] FRAME_HEIGHT_RESET = 11'd1024;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam int HEIGHT_LIMIT = 1024;
  localparam int ROW_BITS     = 10;

  localparam int MED_TAPS   = 9;
  localparam int MED_CENTER = 4;
  localparam int MED_STAGES = 19;

  typedef logic [3:0] tap_t;

  // Compare-exchange pairs of the nine-input median network; the smaller
  // value ends up at the low tap.
  localparam tap_t MED_LO [MED_STAGES] = '{
    4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd0,
    4'd5, 4'd4, 4'd3, 4'd1, 4'd2, 4'd4, 4'd4, 4'd6, 4'd4
  };
  localparam tap_t MED_HI [MED_STAGES] = '{
    4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8, 4'd3,
    4'd8, 4'd7, 4'd6, 4'd4, 4'd5, 4'd7, 4'd2, 4'd4, 4'd2
  };

  typedef struct packed {
    logic is_flush;
    logic row0;
    logic first;
    logic last;
  } stage_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/med3_if.sv -----
// Valid/ready channel interfaces of the 3x3 median filter: pixels, results, configuration.
// Depends on med3_pkg for the configuration field widths.
`timescale 1ns / 1ps
`default_nettype none
interface med3_in_if #(parameter int CHANNEL_BITS = 8);
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic [CHANNEL_BITS-1:0] red_in;
  logic [CHANNEL_BITS-1:0] green_in;
  logic [CHANNEL_BITS-1:0] blue_in;

  modport source (output valid, opcode, red_in, green_in, blue_in, input ready);
  modport sink (input valid, opcode, red_in, green_in, blue_in, output ready);
endinterface

interface med3_out_if #(parameter int CHANNEL_BITS = 8);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red_out;
  logic [CHANNEL_BITS-1:0] green_out;
  logic [CHANNEL_BITS-1:0] blue_out;
  logic                    end_of_frame;

  modport source (output valid, red_out, green_out, blue_out, end_of_frame, input ready);
  modport sink (input valid, red_out, green_out, blue_out, end_of_frame, output ready);
endinterface

interface med3_cfg_if;
  import med3_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/med3_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// Read during a write to the same address returns the old data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module med3_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/median3x3_rgb_filter.sv -----
// Top level of the streaming 3x3 RGB median filter with replicated borders.
// Depends on med3_pkg, the channel interfaces in med3_if.sv, med3_ram and the assert macros.
//
//   channel   role    beat contents
//   pixels    sink    opcode, red_in, green_in, blue_in
//   results   source  red_out, green_out, blue_out, end_of_frame
//   cfg       sink    index, data (frame_width = 0, frame_height = 1)
//
// One beat is accepted per cycle when the window stage can take it; its results are buffered.
// The line store read is registered, so the window and median stage see a beat in the next cycle.
// Below row 0 a row's last pixel gives two results (one if also first); input waits till both fit.
// A two-entry result buffer decouples the output; a stalled output fills it and then stalls input.
// Reset is synchronous; the line stores are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "median3x3_rgb_filter_assert.svh"
module median3x3_rgb_filter #(
  parameter int MAX_WIDTH    = 1024,
  parameter int CHANNEL_BITS = 8
) (
  input wire logic clk,
  input wire logic rst,
  med3_in_if.sink     pixels,
  med3_out_if.source  results,
  med3_cfg_if.sink    cfg
);
  import med3_pkg::*;

  localparam int CB    = CHANNEL_BITS;
  localparam int PIX_W = 3 * CB;
  localparam int COL_W = 3 * PIX_W;
  localparam int RES_W = PIX_W + 1;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = CW + 1;
  localparam int CMP_W = (WW > CFG_DATA_BITS) ? WW : CFG_DATA_BITS;

  function automatic logic [CB-1:0] med9(input logic [MED_TAPS*CB-1:0] v);
    logic [CB-1:0] p [MED_TAPS];
    logic [CB-1:0] t;
    for (int i = 0; i < MED_TAPS; i++) begin
      p[i] = v[i*CB +: CB];
    end
    for (int s = 0; s < MED_STAGES; s++) begin
      if (p[MED_LO[s]] > p[MED_HI[s]]) begin
        t = p[MED_LO[s]];
        p[MED_LO[s]] = p[MED_HI[s]];
        p[MED_HI[s]] = t;
      end
    end
    return p[MED_CENTER];
  endfunction

  function automatic logic [RES_W-1:0] result_of(input logic [COL_W-1:0] ca,
                                                 input logic [COL_W-1:0] cb,
                                                 input logic [COL_W-1:0] cc,
                                                 input logic             eof);
    logic [MED_TAPS*CB-1:0] v;
    logic [PIX_W-1:0]       m;
    for (int ch = 0; ch < 3; ch++) begin
      for (int y = 0; y < 3; y++) begin
        v[(0*3+y)*CB +: CB] = ca[y*PIX_W + ch*CB +: CB];
        v[(1*3+y)*CB +: CB] = cb[y*PIX_W + ch*CB +: CB];
        v[(2*3+y)*CB +: CB] = cc[y*PIX_W + ch*CB +: CB];
      end
      m[ch*CB +: CB] = med9(v);
    end
    return {eof, m};
  endfunction

  // Configuration registers.
  logic [CFG_DATA_BITS-1:0] frame_width;
  logic [CFG_DATA_BITS-1:0] frame_height;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_FRAME_WIDTH:  frame_width  <= cfg.data;
        REG_FRAME_HEIGHT: frame_height <= cfg.data;
        default: ;
      endcase
    end
  end

  logic [WW-1:0]            w_eff;
  logic [CFG_DATA_BITS-1:0] h_eff;

  always_comb begin
    if (frame_width == '0) begin
      w_eff = WW'(1);
    end else if (CMP_W'(frame_width) > CMP_W'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = CFG_DATA_BITS'(1);
    end else if (frame_height > CFG_DATA_BITS'(HEIGHT_LIMIT)) begin
      h_eff = CFG_DATA_BITS'(HEIGHT_LIMIT);
    end else begin
      h_eff = frame_height;
    end
  end

  // Input stage: position counters and line store read.
  logic [CW-1:0]       column_count, column_count_next;
  logic [CW-1:0]       flush_count, flush_count_next;
  logic [ROW_BITS-1:0] row_count, row_count_next;
  logic                flushing, flushing_next;

  logic          acc, is_flush_in, take, load, last_in;
  logic [CW-1:0] c_in;

  logic             s1_valid;
  stage_ctl_t       s1_ctl;
  logic [CW-1:0]    s1_col;
  logic [PIX_W-1:0] s1_pix;
  logic             s1_adv;
  logic             fwd_valid;
  logic [2*PIX_W-1:0] fwd_data;

  logic               ram_we;
  logic [2*PIX_W-1:0] ram_wdata;
  logic [2*PIX_W-1:0] ram_rdata;

  assign pixels.ready = !s1_valid || s1_adv;
  assign acc          = pixels.valid && pixels.ready;
  assign is_flush_in  = (pixels.opcode == OP_FLUSH);
  assign take         = is_flush_in ? flushing : !flushing;
  assign load         = acc && take;
  assign c_in         = is_flush_in ? flush_count : column_count;
  assign last_in      = (WW'(c_in) + WW'(1)) >= w_eff;

  always_comb begin
    column_count_next = column_count;
    flush_count_next  = flush_count;
    row_count_next    = row_count;
    flushing_next     = flushing;
    if (load) begin
      if (is_flush_in) begin
        if (last_in) begin
          flushing_next    = 1'b0;
          flush_count_next = '0;
        end else begin
          flush_count_next = c_in + CW'(1);
        end
      end else if (last_in) begin
        column_count_next = '0;
        if ((CFG_DATA_BITS'(row_count) + CFG_DATA_BITS'(1)) >= h_eff) begin
          row_count_next   = '0;
          flushing_next    = 1'b1;
          flush_count_next = '0;
        end else begin
          row_count_next = row_count + ROW_BITS'(1);
        end
      end else begin
        column_count_next = c_in + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      flush_count  <= '0;
      row_count    <= '0;
      flushing     <= 1'b0;
      s1_valid     <= 1'b0;
      fwd_valid    <= 1'b0;
    end else begin
      column_count <= column_count_next;
      flush_count  <= flush_count_next;
      row_count    <= row_count_next;
      flushing     <= flushing_next;
      if (load) begin
        s1_valid  <= 1'b1;
        fwd_valid <= ram_we && (c_in == s1_col);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_ctl.is_flush <= is_flush_in;
      s1_ctl.row0     <= !is_flush_in && (row_count == '0);
      s1_ctl.first    <= (c_in == '0);
      s1_ctl.last     <= last_in;
      s1_col          <= c_in;
      s1_pix          <= {pixels.blue_in, pixels.green_in, pixels.red_in};
      fwd_data        <= ram_wdata;
    end
  end

  // Each line store entry holds the middle row above the upper row.
  med3_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_col),
    .wdata (ram_wdata),
    .re    (load),
    .raddr (c_in),
    .rdata (ram_rdata)
  );

  // Window and median stage.
  logic [PIX_W-1:0] s1_up, s1_mid;
  logic             produce;
  logic [1:0]       n1;
  logic [COL_W-1:0] col_in;
  logic [COL_W-1:0] win1, win2;
  logic [COL_W-1:0] wn0, wn1, wn2;
  logic [RES_W-1:0] res_a, res_b, item_a;
  logic [1:0]       out_cnt, out_cnt_next, base;
  logic             pop;
  logic [RES_W-1:0] q0, q1, q0_next, q1_next;

  assign s1_up   = fwd_valid ? fwd_data[PIX_W-1:0] : ram_rdata[PIX_W-1:0];
  assign s1_mid  = fwd_valid ? fwd_data[2*PIX_W-1:PIX_W] : ram_rdata[2*PIX_W-1:PIX_W];
  assign produce = s1_ctl.is_flush || !s1_ctl.row0;
  assign n1      = produce ? (2'(!s1_ctl.first) + 2'(s1_ctl.last)) : 2'd0;
  assign s1_adv  = s1_valid && (n1 <= (2'd2 - out_cnt));

  assign ram_we    = s1_adv && !s1_ctl.is_flush;
  assign ram_wdata = {s1_pix, s1_ctl.row0 ? s1_pix : s1_mid};

  assign col_in = {s1_ctl.is_flush ? s1_mid : s1_pix, s1_mid, s1_up};

  always_comb begin
    if (s1_ctl.first) begin
      wn0 = col_in;
      wn1 = col_in;
      wn2 = col_in;
    end else begin
      wn0 = win1;
      wn1 = win2;
      wn2 = col_in;
    end
  end

  assign res_a  = result_of(wn0, wn1, wn2, 1'b0);
  assign res_b  = result_of(wn1, wn2, wn2, s1_ctl.is_flush && s1_ctl.last);
  assign item_a = s1_ctl.first ? res_b : res_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      win1 <= '0;
      win2 <= '0;
    end else if (s1_adv && produce) begin
      win1 <= wn1;
      win2 <= wn2;
    end
  end

  // Two-entry result buffer; q0 is the head.
  assign pop  = (out_cnt != 2'd0) && results.ready;
  assign base = out_cnt - 2'(pop);

  always_comb begin
    q0_next = pop ? q1 : q0;
    q1_next = q1;
    if (s1_adv && (n1 != 2'd0)) begin
      if (base == 2'd0) begin
        q0_next = item_a;
      end else begin
        q1_next = item_a;
      end
      if (n1 == 2'd2) begin
        q1_next = res_b;
      end
    end
    out_cnt_next = base + (s1_adv ? n1 : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt <= 2'd0;
    end else begin
      out_cnt <= out_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    q0 <= q0_next;
    q1 <= q1_next;
  end

  assign results.valid        = (out_cnt != 2'd0);
  assign results.red_out      = q0[CB-1:0];
  assign results.green_out    = q0[2*CB-1:CB];
  assign results.blue_out     = q0[3*CB-1:2*CB];
  assign results.end_of_frame = q0[PIX_W];

  `MED3_ASSERT_ALWAYS(a_buf_fill, out_cnt <= 2'd2, "result buffer fill above two")
  `MED3_ASSERT_NEXT(a_pixel_dropped, acc && !is_flush_in && flushing, !s1_valid,
                    "pixel during flush reached the window stage")
  `MED3_ASSERT_IMPLIES(a_flush_done, s1_adv && s1_ctl.is_flush && s1_ctl.last, !flushing,
                       "frame still flushing after its last flush beat")

endmodule
`default_nettype wire

// ----- test/tb_median3x3_rgb_filter.sv -----
// Self-checking testbench of the streaming 3x3 RGB median filter with replicated borders.
// Depends on med3_pkg, the channel interfaces of med3_if.sv and the median3x3_rgb_filter RTL.
// A built-in predictor computes the medians of untyped beats, and a scoreboard compares them.
`timescale 1ns / 1ps
module tb_median3x3_rgb_filter;
  import med3_pkg::*;

  localparam int          LINE_DEPTH   = 1024;
  localparam int          CHAN_BITS    = 8;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          HOLD_CYCLES  = 300;
  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam int          PLAN_ROWS    = 25;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       eof;
  } median_t;

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic [CFG_INDEX_BITS-1:0] reg_index;
    logic [CFG_DATA_BITS-1:0]  reg_value;
    logic                      op;
    logic [7:0]                red;
    logic [7:0]                green;
    logic [7:0]                blue;
    logic                      typed;
    logic [1:0]                typed_n;
    median_t                   typed_res;
  } plan_row_t;

  // Rows marked typed carry the expected outcome; other beat rows rely on the predictor.
  localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    '{ROW_BEAT, REG_FRAME_WIDTH, 11'd0, OP_FLUSH, 8'h00, 8'h00, 8'h00, 1'b1, 2'd0, '0},
    '{ROW_BEAT, REG_FRAME_WIDTH, 11'd0, OP_PIXEL, 8'h00, 8'hff, 8'h80, 1'b1, 2'd0, '0},
    '{ROW_REG, REG_FRAME_WIDTH, 11'd0, OP_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0, 2'd0, '0},
    '{ROW_REG, REG_FRAME_HEIGHT, 11'd0, OP_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0, 2'd0, '0},
    '{ROW_BEAT, REG_FRAME_WIDTH, 11'd0, OP_PIXEL, 8'hff, 8'hff, 8'hff, 1'b1, 2'd0, '0},
    '{ROW_BEAT, REG_FRAME_WIDTH, 11'd0, OP_PIXEL, 8'h12, 8'h34, 8'h56, 1'b1, 2'd0, '0},
    '{ROW_BEAT, REG_FRAME_WIDTH, 11'd0, OP_FLUSH, 8'h00, 8'h00, 8'h00, 1'b1, 2'd1,
      '{8'h00, 8'hff, 8'h80, 1'b1}},
    '{ROW_BEAT, REG_FRAME_WIDTH, 11'd0, OP_FLUSH, 8'hff, 8'hff, 8'hff, 1'b1, 2'd0, '0},
    '{ROW_REG, REG_FRAME_WIDTH, 11'd3, OP_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0, 2'd0, '0},
    '{ROW_REG, REG_FRAME_HEIGHT, 11'd2, OP_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0, 2'd0, '0},
    '{ROW_BEAT, REG_FRAME_WIDTH, 11'd0, OP_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0, 2'd0, '0},
    '{ROW_BEAT, REG_FRAME_WIDTH, 11'd0, OP_PIXEL, 8'hff, 8'hff, 8'hff, 1'b0, 2'd0, '0},
    '{ROW_BEAT, REG_FRAME_WIDTH, 11'd0, OP_PIXEL, 8'h01, 8'h80, 8'hfe, 1'b0, 2'd0, '0},
    '{ROW_BEAT, REG_FRAME_WIDTH, 11'd0, OP_PIXEL, 8'hff, 8'h00, 8'hff, 1'b0, 2'd0, '0},
    '{ROW_BEAT, REG_FRAME_WIDTH, 11'd0, OP_PIXEL, 8'h7f, 8'h80, 8'h00, 1'b0, 2'd0, '0},
    '{ROW_BEAT, REG_FRAME_WIDTH, 11'd0, OP_PIXEL, 8'h00, 8'hff, 8'h01, 1'b0, 2'd0, '0},
    '{ROW_BEAT, REG_FRAME_WIDTH, 11'd0, OP_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0, 2'd0, '0},
    '{ROW_BEAT, REG_FRAME_WIDTH, 11'd0, OP_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0, 2'd0, '0},
    '{ROW_BEAT, REG_FRAME_WIDTH, 11'd0, OP_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0, 2'd0, '0},
    '{ROW_REG, REG_FRAME_WIDTH, 11'd1, OP_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0, 2'd0, '0},
    '{ROW_REG, REG_FRAME_HEIGHT, 11'd3, OP_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0, 2'd0, '0},
    '{ROW_BEAT, REG_FRAME_WIDTH, 11'd0, OP_PIXEL, 8'haa, 8'h55, 8'h0f, 1'b1, 2'd0, '0},
    '{ROW_BEAT, REG_FRAME_WIDTH, 11'd0, OP_PIXEL, 8'h10, 8'h20, 8'h30, 1'b0, 2'd0, '0},
    '{ROW_BEAT, REG_FRAME_WIDTH, 11'd0, OP_PIXEL, 8'hff, 8'h00, 8'h80, 1'b0, 2'd0, '0},
    '{ROW_BEAT, REG_FRAME_WIDTH, 11'd0, OP_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0, 2'd0, '0}
  };

  logic clk;
  logic rst;

  med3_in_if #(.CHANNEL_BITS(CHAN_BITS))  pix_if ();
  med3_out_if #(.CHANNEL_BITS(CHAN_BITS)) res_if ();
  med3_cfg_if                             cfg_if ();

  median3x3_rgb_filter #(
    .MAX_WIDTH(LINE_DEPTH),
    .CHANNEL_BITS(CHAN_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .pixels(pix_if),
    .results(res_if),
    .cfg(cfg_if)
  );

  // Predictor state.
  logic [23:0]              upper_row [LINE_DEPTH];
  logic [23:0]              middle_row [LINE_DEPTH];
  logic [23:0]              window_px [3][3];
  int unsigned              row_idx = 0;
  int unsigned              col_idx = 0;
  int unsigned              flush_idx = 0;
  bit                       awaiting_flush = 1'b0;
  logic [CFG_DATA_BITS-1:0] width_reg = FRAME_WIDTH_RESET;
  logic [CFG_DATA_BITS-1:0] height_reg = FRAME_HEIGHT_RESET;

  median_t     pending_medians [$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // Shared between the stimulus, the beat driver, the result sink and the scoreboard.
  logic        beat_typed = 1'b0;
  logic [1:0]  beat_typed_n = '0;
  median_t     beat_typed_res = '0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned hold_requests = 0;

  function automatic int unsigned active_width();
    if (width_reg == 0) return 1;
    if (width_reg > LINE_DEPTH) return LINE_DEPTH;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    if (height_reg == 0) return 1;
    if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
    return height_reg;
  endfunction

  function automatic logic [7:0] median_of_nine(input logic [71:0] vals);
    logic [7:0] s [9];
    logic [7:0] t;
    int j;
    for (int i = 0; i < 9; i++) s[i] = vals[i*8 +: 8];
    for (int i = 1; i < 9; i++) begin
      j = i;
      while (j > 0 && s[j-1] > s[j]) begin
        t = s[j];
        s[j] = s[j-1];
        s[j-1] = t;
        j--;
      end
    end
    return s[4];
  endfunction

  function automatic median_t window_median(input int a, input int b, input int c,
                                            input logic eof);
    median_t m;
    logic [71:0] vals;
    logic [7:0] chan [3];
    int cols [3];
    cols[0] = a;
    cols[1] = b;
    cols[2] = c;
    for (int ch = 0; ch < 3; ch++) begin
      for (int x = 0; x < 3; x++) begin
        for (int y = 0; y < 3; y++) begin
          vals[(x*3 + y)*8 +: 8] = window_px[cols[x]][y][ch*8 +: 8];
        end
      end
      chan[ch] = median_of_nine(vals);
    end
    m.red = chan[0];
    m.green = chan[1];
    m.blue = chan[2];
    m.eof = eof;
    return m;
  endfunction

  function automatic int shift_in_column(input logic [23:0] top, input logic [23:0] mid,
                                         input logic [23:0] bot, input bit first,
                                         input bit last, input logic eof,
                                         output median_t ra, output median_t rb);
    int n;
    median_t m;
    n = 0;
    ra = '0;
    rb = '0;
    if (first) begin
      for (int x = 0; x < 3; x++) begin
        window_px[x][0] = top;
        window_px[x][1] = mid;
        window_px[x][2] = bot;
      end
    end else begin
      for (int y = 0; y < 3; y++) begin
        window_px[0][y] = window_px[1][y];
        window_px[1][y] = window_px[2][y];
      end
      window_px[2][0] = top;
      window_px[2][1] = mid;
      window_px[2][2] = bot;
      ra = window_median(0, 1, 2, 1'b0);
      n = 1;
    end
    if (last) begin
      m = window_median(1, 2, 2, eof);
      if (n == 0) ra = m;
      else rb = m;
      n++;
    end
    return n;
  endfunction

  function automatic int predict_beat(input logic op, input logic [23:0] pix,
                                      output median_t ra, output median_t rb);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    bit last;
    int n;
    w = active_width();
    h = active_height();
    n = 0;
    ra = '0;
    rb = '0;
    if (op == OP_PIXEL) begin
      if (awaiting_flush) return 0;
      c = (col_idx >= LINE_DEPTH) ? LINE_DEPTH - 1 : col_idx;
      last = (c + 1 >= w);
      if (row_idx == 0) begin
        upper_row[c] = pix;
        middle_row[c] = pix;
      end else begin
        n = shift_in_column(upper_row[c], middle_row[c], pix, c == 0, last, 1'b0, ra, rb);
        upper_row[c] = middle_row[c];
        middle_row[c] = pix;
      end
      if (last) begin
        col_idx = 0;
        if (row_idx + 1 >= h) begin
          row_idx = 0;
          awaiting_flush = 1'b1;
          flush_idx = 0;
        end else begin
          row_idx++;
        end
      end else begin
        col_idx = c + 1;
      end
    end else begin
      if (!awaiting_flush) return 0;
      c = (flush_idx >= LINE_DEPTH) ? LINE_DEPTH - 1 : flush_idx;
      last = (c + 1 >= w);
      n = shift_in_column(upper_row[c], middle_row[c], middle_row[c], c == 0, last, last,
                          ra, rb);
      if (last) begin
        awaiting_flush = 1'b0;
        flush_idx = 0;
      end else begin
        flush_idx = c + 1;
      end
    end
    return n;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Scoreboard: applies register writes and pixel beats to the predictor, then checks results.
  always @(posedge clk) begin : scoreboard
    bit      accepted;
    int      n;
    median_t ra;
    median_t rb;
    median_t got;
    median_t want;
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      accepted = 1'b0;
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.index == REG_FRAME_WIDTH) width_reg = cfg_if.data;
        else if (cfg_if.index == REG_FRAME_HEIGHT) height_reg = cfg_if.data;
        accepted = 1'b1;
      end
      if (pix_if.valid && pix_if.ready) begin
        n = predict_beat(pix_if.opcode, {pix_if.blue_in, pix_if.green_in, pix_if.red_in},
                         ra, rb);
        if (beat_typed) begin
          n = beat_typed_n;
          ra = beat_typed_res;
        end
        if (n > 0) pending_medians.push_back(ra);
        if (n > 1) pending_medians.push_back(rb);
        accepted = 1'b1;
      end
      if (res_if.valid && res_if.ready) begin
        got = '{res_if.red_out, res_if.green_out, res_if.blue_out, res_if.end_of_frame};
        if (pending_medians.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: r=%h g=%h b=%h eof=%b",
                     got.red, got.green, got.blue, got.eof);
        end else begin
          want = pending_medians.pop_front();
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.eof !== want.eof) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp r=%h g=%h b=%h eof=%b got r=%h g=%h b=%h eof=%b",
                       want.red, want.green, want.blue, want.eof,
                       got.red, got.green, got.blue, got.eof);
          end
        end
        accepted = 1'b1;
      end
      quiet_cycles = accepted ? 0 : quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  initial begin : result_sink
    int unsigned served;
    int unsigned hold_left;
    served = 0;
    hold_left = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && served != hold_requests) begin
        served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        res_if.ready = 1'b0;
        hold_left--;
      end else begin
        res_if.ready = ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // All driving tasks start and end at a falling edge.
  task automatic send_beat(input logic op, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b, input logic typed, input logic [1:0] typed_n,
                           input median_t typed_res);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_if.valid = 1'b0;
      @(negedge clk);
    end
    beat_typed = typed;
    beat_typed_n = typed_n;
    beat_typed_res = typed_res;
    pix_if.opcode = op;
    pix_if.red_in = r;
    pix_if.green_in = g;
    pix_if.blue_in = b;
    pix_if.valid = 1'b1;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(input logic op);
    send_beat(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 1'b0, 2'd0, '0);
  endtask

  task automatic settle();
    pix_if.valid = 1'b0;
    while (pending_medians.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg_if.index = index;
    cfg_if.data = value;
    cfg_if.valid = 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Within a frame the width may only shrink, so no line store entry is read unwritten.
  task automatic choose_frame(input bit grow_ok);
    int unsigned pick;
    int unsigned w;
    settle();
    pick = $urandom_range(9);
    if (!grow_ok) w = $urandom_range(1, active_width());
    else if (pick == 0) w = 0;
    else if (pick == 1) w = $urandom_range(9, 40);
    else w = $urandom_range(1, 8);
    write_reg(REG_FRAME_WIDTH, CFG_DATA_BITS'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_BITS'($urandom_range(0, 5)));
  endtask

  // Mostly well-formed frames, with a few beats that the filter has to ignore.
  task automatic run_random(input int unsigned beats_wanted);
    int unsigned done;
    bit frame_start;
    bit noise;
    done = 0;
    while (done < beats_wanted) begin
      frame_start = !awaiting_flush && row_idx == 0 && col_idx == 0;
      if (frame_start && $urandom_range(3) == 0) choose_frame(1'b1);
      else if (!frame_start && $urandom_range(149) == 0) choose_frame(1'b0);
      noise = ($urandom_range(19) == 0);
      if (!noise) done++;
      if (awaiting_flush != noise) send_random(OP_FLUSH);
      else send_random(OP_PIXEL);
    end
  endtask

  initial begin : stimulus
    plan_row_t row;
    rst = 1'b1;
    pix_if.valid = 1'b0;
    pix_if.opcode = OP_PIXEL;
    pix_if.red_in = '0;
    pix_if.green_in = '0;
    pix_if.blue_in = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_FRAME_WIDTH;
    cfg_if.data = '0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < PLAN_ROWS; i++) begin
      row = DIRECTED_PLAN[i];
      if (row.kind == ROW_REG) begin
        settle();
        write_reg(row.reg_index, row.reg_value);
      end else begin
        send_beat(row.op, row.red, row.green, row.blue, row.typed, row.typed_n,
                  row.typed_res);
      end
    end

    // Out-of-range sizes, then both sizes shrink in the middle of the frame.
    settle();
    write_reg(REG_FRAME_WIDTH, 11'h7ff);
    write_reg(REG_FRAME_HEIGHT, 11'h7ff);
    for (int i = 0; i < 6; i++) send_random(OP_PIXEL);
    settle();
    write_reg(REG_FRAME_WIDTH, 11'd7);
    send_random(OP_PIXEL);
    settle();
    write_reg(REG_FRAME_HEIGHT, 11'd2);
    for (int i = 0; i < 7; i++) send_random(OP_PIXEL);
    for (int i = 0; i < 7; i++) send_random(OP_FLUSH);

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: begin
          src_idle_pct = 0;
          snk_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 51;
          snk_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          snk_stall_pct = 51;
        end
        default: begin
          src_idle_pct = 6;
          snk_stall_pct = 6;
        end
      endcase
      if (!awaiting_flush && row_idx == 0 && col_idx == 0) choose_frame(1'b1);
      else choose_frame(1'b0);
      if (ph == 0) hold_requests++;
      run_random(170);
    end

    pix_if.valid = 1'b0;
    while (pending_medians.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0 && pending_medians.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/med3_pkg.sv
rtl/med3_if.sv
rtl/med3_ram.sv
rtl/median3x3_rgb_filter.sv
test/tb_median3x3_rgb_filter.sv
